>>> rtl/core/spg_pkg.sv
// Shared types, codes and default sizes for the Sobol point generator.
// No dependencies; the front end, back end, top level and bench import it.
`default_nettype none
package spg_pkg;

   localparam int DEF_MAX_DIMS = 16;
   localparam int DEF_NUM_COLS = 32;
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RESULT_DEPTH = 4;
   localparam int EMIT_LIMIT = 16;

   typedef enum logic [1:0] {
      CMD_LOAD_DIR   = 2'd0,
      CMD_LOAD_SHIFT = 2'd1,
      CMD_RESTART    = 2'd2,
      CMD_NEXT       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DIMS_IN_USE  = 2'd0,
      CSR_SHIFT_ENABLE = 2'd1,
      CSR_START_INDEX  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_LOAD_DIR,
      OP_LOAD_SHIFT,
      OP_RESTART,
      OP_NEXT,
      OP_EXHAUST,
      OP_CLEAR_EXHAUST
   } op_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  dim;
      logic [4:0]  col;
      logic [31:0] word;
   } cmd_entry_type;

   typedef struct packed {
      logic [3:0]  coord_dim;
      logic [31:0] coord_value;
      logic        status;
      logic        last_of_point;
   } result_type;

   typedef struct packed {
      logic [4:0] dims_in_use;
      logic       shift_enable;
   } back_cfg_type;

   typedef struct packed {
      logic full;
      logic room_two;
   } res_space_type;

endpackage
`default_nettype wire

>>> rtl/core/spg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module spg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> rtl/core/spg_fifo.sv
// Small register-based FIFO used for the command queue and the result queue.
// No dependencies.
`default_nettype none
module spg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign level    = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/spg_front.sv
// Front end: accepts items, tracks the sequence index and classifies items.
// Depends on spg_pkg.
`default_nettype none
module spg_front #(
   parameter int MAX_DIMS = spg_pkg::DEF_MAX_DIMS,
   parameter int NUM_COLS = spg_pkg::DEF_NUM_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  queue_full,
   input  logic [1:0]            cmd,
   input  logic [3:0]            dim_index,
   input  logic [4:0]            column_index,
   input  logic [31:0]           load_word,
   input  logic [31:0]           start_index,
   output logic                  entry_push,
   output spg_pkg::cmd_entry_type entry
);
   import spg_pkg::*;

   localparam logic [32:0] LAST_INDEX = 33'((64'd1 << NUM_COLS) - 64'd1);

   logic [31:0] counter_ff, counter_in;
   logic        accept, keep;
   logic [4:0]  zero_col;

   assign accept = push && !queue_full;

   // lowest zero bit of the index, top column when all lower bits are set
   always_comb begin
      zero_col = 5'(NUM_COLS - 1);
      for (int c = NUM_COLS - 2; c >= 0; c--) begin
         if (!counter_ff[c]) begin
            zero_col = 5'(c);
         end
      end
   end

   always_comb begin
      counter_in = counter_ff;
      keep       = 1'b0;
      entry.op   = OP_LOAD_DIR;
      entry.dim  = dim_index;
      entry.col  = column_index;
      entry.word = load_word;
      unique case (cmd_type'(cmd))
         CMD_LOAD_DIR: begin
            keep = (int'(dim_index) < MAX_DIMS) && (int'(column_index) < NUM_COLS);
         end
         CMD_LOAD_SHIFT: begin
            keep     = (int'(dim_index) < MAX_DIMS);
            entry.op = OP_LOAD_SHIFT;
         end
         CMD_RESTART: begin
            keep       = 1'b1;
            counter_in = start_index;
            entry.word = start_index ^ (start_index >> 1);
            entry.op   = ({1'b0, start_index} > LAST_INDEX) ? OP_CLEAR_EXHAUST : OP_RESTART;
         end
         CMD_NEXT: begin
            keep = 1'b1;
            if ({1'b0, counter_ff} >= LAST_INDEX) begin
               entry.op = OP_EXHAUST;
            end else begin
               entry.op   = OP_NEXT;
               entry.col  = zero_col;
               counter_in = counter_ff + 32'd1;
            end
         end
         default: keep = 1'b0;
      endcase
   end

   assign entry_push = accept && keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (accept) begin
         counter_ff <= counter_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/spg_back.sv
// Back end: direction RAM, shift words, current point and the XOR sequencer.
// Depends on spg_pkg and spg_ram.
`default_nettype none
module spg_back #(
   parameter int MAX_DIMS = spg_pkg::DEF_MAX_DIMS,
   parameter int NUM_COLS = spg_pkg::DEF_NUM_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   input  spg_pkg::cmd_entry_type cmd_entry,
   output logic                   cmd_pop,
   input  spg_pkg::back_cfg_type  cfg,
   input  spg_pkg::res_space_type res_space,
   output logic                   res_push,
   output spg_pkg::result_type    res_entry
);
   import spg_pkg::*;

   localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int COL_W  = $clog2(NUM_COLS);
   localparam int DEPTH  = MAX_DIMS * NUM_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CAP    = (MAX_DIMS < EMIT_LIMIT) ? MAX_DIMS : EMIT_LIMIT;

   back_state_type state_ff, state_in;
   logic [DIM_W-1:0]    id_ff, id_in, pd_ff, pd_in;
   logic [COL_W-1:0]    ic_ff, ic_in, pc_ff, pc_in, ncol_ff, ncol_in;
   logic                issuing_ff, issuing_in, pv_ff, pv_in, is_next_ff, is_next_in;
   logic [NUM_COLS-1:0] gray_ff, gray_in;
   logic [31:0]         acc_ff, acc_in;
   logic [31:0]         cur_ff [MAX_DIMS];
   logic [31:0]         shift_ff [MAX_DIMS];

   logic                issue, last_issue, done_dim, cur_clear, shift_wr;
   logic [COL_W-1:0]    rd_col;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic                wr_en;
   logic [31:0]         rd_data, base, term, val;
   logic [4:0]          n_dims;

   spg_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_dir_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(cmd_entry.word),
      .rd_en  (issue),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // clamp the emitted dimension count to 1 .. CAP
   always_comb begin
      if (cfg.dims_in_use == 5'd0) begin
         n_dims = 5'd1;
      end else if (int'(cfg.dims_in_use) > CAP) begin
         n_dims = 5'(CAP);
      end else begin
         n_dims = cfg.dims_in_use;
      end
   end

   assign rd_col  = is_next_ff ? ncol_ff : ic_ff;
   assign rd_addr = ADDR_W'(int'(id_ff) * NUM_COLS + int'(rd_col));
   assign wr_addr = ADDR_W'(int'(cmd_entry.dim) * NUM_COLS + int'(cmd_entry.col));
   assign issue   = (state_ff == BACK_RUN) && issuing_ff && res_space.room_two;
   assign last_issue = (id_ff == DIM_W'(MAX_DIMS - 1))
                       && (is_next_ff || (ic_ff == COL_W'(NUM_COLS - 1)));

   // returned word: fold into the accumulator or the current coordinate
   assign base = is_next_ff ? cur_ff[pd_ff] : ((pc_ff == '0) ? 32'd0 : acc_ff);
   assign term = (is_next_ff || gray_ff[pc_ff]) ? rd_data : 32'd0;
   assign val  = base ^ term;
   assign done_dim = pv_ff && (is_next_ff || (pc_ff == COL_W'(NUM_COLS - 1)));

   always_comb begin
      state_in   = state_ff;
      id_in      = id_ff;
      ic_in      = ic_ff;
      issuing_in = issuing_ff;
      is_next_in = is_next_ff;
      gray_in    = gray_ff;
      ncol_in    = ncol_ff;
      pv_in      = issue;
      pd_in      = id_ff;
      pc_in      = rd_col;
      acc_in     = pv_ff ? val : acc_ff;
      cmd_pop    = 1'b0;
      wr_en      = 1'b0;
      shift_wr   = 1'b0;
      cur_clear  = 1'b0;
      res_push   = 1'b0;
      res_entry.coord_dim     = 4'(pd_ff);
      res_entry.coord_value   = val ^ (cfg.shift_enable ? shift_ff[pd_ff] : 32'd0);
      res_entry.status        = 1'b0;
      res_entry.last_of_point = (5'(pd_ff) == n_dims - 5'd1);

      unique case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty) begin
               unique case (cmd_entry.op)
                  OP_LOAD_DIR: begin
                     cmd_pop = 1'b1;
                     wr_en   = 1'b1;
                  end
                  OP_LOAD_SHIFT: begin
                     cmd_pop  = 1'b1;
                     shift_wr = 1'b1;
                  end
                  OP_RESTART, OP_NEXT: begin
                     cmd_pop    = 1'b1;
                     is_next_in = (cmd_entry.op == OP_NEXT);
                     gray_in    = cmd_entry.word[NUM_COLS-1:0];
                     ncol_in    = cmd_entry.col[COL_W-1:0];
                     id_in      = '0;
                     ic_in      = '0;
                     issuing_in = 1'b1;
                     state_in   = BACK_RUN;
                  end
                  OP_EXHAUST, OP_CLEAR_EXHAUST: begin
                     if (!res_space.full) begin
                        cmd_pop   = 1'b1;
                        res_push  = 1'b1;
                        cur_clear = (cmd_entry.op == OP_CLEAR_EXHAUST);
                        res_entry.coord_dim     = 4'd0;
                        res_entry.coord_value   = 32'd0;
                        res_entry.status        = 1'b1;
                        res_entry.last_of_point = 1'b1;
                     end
                  end
                  default: cmd_pop = 1'b0;
               endcase
            end
         end
         BACK_RUN: begin
            res_push = done_dim && (5'(pd_ff) < n_dims);
            if (issue) begin
               if (last_issue) begin
                  issuing_in = 1'b0;
               end else if (is_next_ff || (ic_ff == COL_W'(NUM_COLS - 1))) begin
                  ic_in = '0;
                  id_in = id_ff + 1'b1;
               end else begin
                  ic_in = ic_ff + 1'b1;
               end
            end
            if (!issuing_ff && !pv_ff) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BACK_IDLE;
         issuing_ff <= 1'b0;
         pv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issuing_ff <= issuing_in;
         pv_ff      <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      ic_ff      <= ic_in;
      pd_ff      <= pd_in;
      pc_ff      <= pc_in;
      is_next_ff <= is_next_in;
      gray_ff    <= gray_in;
      ncol_ff    <= ncol_in;
      acc_ff     <= acc_in;
      if (shift_wr) begin
         shift_ff[DIM_W'(cmd_entry.dim)] <= cmd_entry.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cur_clear) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            cur_ff[d] <= '0;
         end
      end else if (done_dim) begin
         cur_ff[pd_ff] <= val;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/sobol_point_generator_core.sv
// Top level of the Sobol point generator: CSR block, front end, command
// queue, back end and result queue. Depends on spg_pkg, spg_front, spg_fifo, spg_back and spg_ram.
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+----------------------------------
//   request   | in        | push / full         | req_cmd, req_dim_index,
//             |           |                     | req_column_index, req_load_word
//   result    | out       | pop / empty         | rsp_coord_dim, rsp_coord_value,
//             |           |                     | rsp_status, rsp_last_of_point
//   csr       | in/out    | psel/penable/pready | paddr, pwdata, prdata (32 bit)
//
// Work: a load or an exhausted item is retired straight from the idle state. A next
// item reads MAX_DIMS direction words, a restart MAX_DIMS * NUM_COLS words; both
// are paced by the single read port of the direction RAM, one word per cycle while
// the result queue has two free words. Reset clears control state and the current point;
// the direction and shift tables hold garbage until loaded.
// Stalls: the front accepts while the command queue has room; a result queue
// short of two free words holds back direction reads.
`default_nettype none
module sobol_point_generator_core #(
   parameter int MAX_DIMS = spg_pkg::DEF_MAX_DIMS,
   parameter int NUM_COLS = spg_pkg::DEF_NUM_COLS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_dim_index,
   input  logic [4:0]  req_column_index,
   input  logic [31:0] req_load_word,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_coord_dim,
   output logic [31:0] rsp_coord_value,
   output logic        rsp_status,
   output logic        rsp_last_of_point,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import spg_pkg::*;

   localparam int CMD_W = $bits(cmd_entry_type);
   localparam int RES_W = $bits(result_type);
   localparam int LVL_W = $clog2(RESULT_DEPTH + 1);

   // CSR registers
   logic [4:0]  dims_ff;
   logic        shen_ff;
   logic [31:0] start_ff;
   logic        csr_write;

   // front to queue to back
   logic          entry_push, cmdq_full, cmdq_empty, cmdq_pop;
   cmd_entry_type entry, cmdq_head;

   // back to result queue
   logic          res_push, res_full;
   result_type    res_entry, res_head;
   logic [LVL_W-1:0] res_level;
   res_space_type res_space;
   back_cfg_type  back_cfg;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // write at the access phase; addresses past the list drop
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= 5'd1;
         shen_ff  <= 1'b0;
         start_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(paddr[3:2]))
            CSR_DIMS_IN_USE:  dims_ff  <= pwdata[4:0];
            CSR_SHIFT_ENABLE: shen_ff  <= pwdata[0];
            CSR_START_INDEX:  start_ff <= pwdata;
            default:          dims_ff  <= dims_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(paddr[3:2]))
         CSR_DIMS_IN_USE:  prdata = {27'd0, dims_ff};
         CSR_SHIFT_ENABLE: prdata = {31'd0, shen_ff};
         CSR_START_INDEX:  prdata = start_ff;
         default:          prdata = 32'd0;
      endcase
   end

   spg_front #(.MAX_DIMS(MAX_DIMS), .NUM_COLS(NUM_COLS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_full  (cmdq_full),
      .cmd         (req_cmd),
      .dim_index   (req_dim_index),
      .column_index(req_column_index),
      .load_word   (req_load_word),
      .start_index (start_ff),
      .entry_push  (entry_push),
      .entry       (entry)
   );

   assign full = cmdq_full;

   spg_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_QUEUE_DEPTH)) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (entry_push),
      .push_data(entry),
      .full     (cmdq_full),
      .pop      (cmdq_pop),
      .pop_data (cmdq_head),
      .empty    (cmdq_empty),
      .level    ()
   );

   assign back_cfg.dims_in_use  = dims_ff;
   assign back_cfg.shift_enable = shen_ff;
   // two free words cover one read in flight plus the word it returns
   assign res_space.full     = res_full;
   assign res_space.room_two = (int'(res_level) <= RESULT_DEPTH - 2);

   spg_back #(.MAX_DIMS(MAX_DIMS), .NUM_COLS(NUM_COLS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmdq_empty),
      .cmd_entry(cmdq_head),
      .cmd_pop  (cmdq_pop),
      .cfg      (back_cfg),
      .res_space(res_space),
      .res_push (res_push),
      .res_entry(res_entry)
   );

   spg_fifo #(.WIDTH(RES_W), .DEPTH(RESULT_DEPTH)) u_res_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_entry),
      .full     (res_full),
      .pop      (pop),
      .pop_data (res_head),
      .empty    (empty),
      .level    (res_level)
   );

   assign rsp_coord_dim     = res_head.coord_dim;
   assign rsp_coord_value   = res_head.coord_value;
   assign rsp_status        = res_head.status;
   assign rsp_last_of_point = res_head.last_of_point;
endmodule
`default_nettype wire

>>> rtl/core/spg_checker.sv
// Port-level checks for the Sobol point generator, bound to the top level.
// Depends on sobol_point_generator_core.
`default_nettype none
module spg_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [3:0]  rsp_coord_dim,
   input logic [31:0] rsp_coord_value,
   input logic        rsp_status,
   input logic        rsp_last_of_point
);
   // reset drains both queues
   a_reset_clears: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not clear after reset");

   // a waiting word holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_coord_value) && $stable(rsp_coord_dim)
                            && $stable(rsp_status) && $stable(rsp_last_of_point)))
      else $error("result word changed while stalled");

   // an exhausted word is a lone, zeroed, final word
   a_exhaust_form: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status) |-> (rsp_last_of_point && rsp_coord_value == 32'd0
                                  && rsp_coord_dim == 4'd0))
      else $error("malformed exhausted word");

   // the first coordinate of a point is dimension zero
   a_first_dim: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_last_of_point) ##1 (!empty && !rsp_status && !$past(reset))
      |-> (rsp_coord_dim == 4'd0))
      else $error("point did not start at dimension zero");
endmodule

bind sobol_point_generator_core spg_checker u_spg_checker (.*);
`default_nettype wire

>>> bench/sobol_point_generator_core_tb.sv
// Self-checking bench for sobol_point_generator_core: fills the direction and shift tables,
// walks a directed plan, then random phases, checking every coordinate word.
// Depends on spg_pkg and the block's RTL; needs nothing else.
module sobol_point_generator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spg_pkg::*;

   localparam int MAX_DIMS = DEF_MAX_DIMS;
   localparam int NUM_COLS = DEF_NUM_COLS;
   localparam int POINT_CAP = (MAX_DIMS < EMIT_LIMIT) ? MAX_DIMS : EMIT_LIMIT;
   localparam longint unsigned LAST_INDEX = (64'd1 << NUM_COLS) - 64'd1;
   localparam int RANDOM_PHASES = 8;
   localparam int WORDS_PER_PHASE = 25;
   localparam int IDLE_PERCENT = 34;
   // Loads leave no result behind; give the back end time to retire them.
   localparam int DRAIN_CYCLES = 40;
   // A restart walks the whole direction RAM once; wait at least that long at the end.
   localparam int SETTLE_CYCLES = MAX_DIMS * NUM_COLS + 64;
   localparam int STALL_LIMIT = 20000;
   localparam result_type EXHAUSTED_WORD = {4'd0, 32'd0, 1'b1, 1'b1};

   // One line of the directed plan: a register write or a request word.
   typedef struct {
      bit            is_csr;
      csr_index_type reg_sel;
      logic [31:0]   reg_value;
      cmd_type       cmd;
      logic [3:0]    dim;
      logic [4:0]    col;
      logic [31:0]   word;
      bit            typed;
      result_type    want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   cmd_type     req_cmd = CMD_NEXT;
   logic [3:0]  req_dim_index = '0;
   logic [4:0]  req_column_index = '0;
   logic [31:0] req_load_word = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [3:0]  rsp_coord_dim;
   logic [31:0] rsp_coord_value;
   logic        rsp_status;
   logic        rsp_last_of_point;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Predictor state: tables, current point, index and the register copies.
   logic [31:0] dir_words [MAX_DIMS][NUM_COLS];
   logic [31:0] shift_words [MAX_DIMS];
   logic [31:0] point [MAX_DIMS];
   logic [31:0] seq_index;
   logic [4:0]  dims_reg;
   logic        shift_reg;
   logic [31:0] start_reg;
   result_type  coord_queue [$];

   bit          steady = 1'b0;
   int unsigned failures = 0;
   int unsigned words_sent = 0;
   int unsigned coords_checked = 0;
   int unsigned exhausted_seen = 0;
   int unsigned csr_writes = 0;
   int unsigned quiet_cycles = 0;

   sobol_point_generator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_dim_index    (req_dim_index),
      .req_column_index (req_column_index),
      .req_load_word    (req_load_word),
      .empty            (empty),
      .pop              (pop),
      .rsp_coord_dim    (rsp_coord_dim),
      .rsp_coord_value  (rsp_coord_value),
      .rsp_status       (rsp_status),
      .rsp_last_of_point(rsp_last_of_point),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Emit the current point: one word per dimension in use, shift applied on request.
   function automatic void queue_point();
      int n;
      int k;
      result_type r;
      n = int'(dims_reg);
      // a count of zero acts as one; anything past the cap saturates
      if (n < 1) n = 1;
      if (n > POINT_CAP) n = POINT_CAP;
      for (k = 0; k < n; k++) begin
         r.coord_dim = 4'(k);
         r.coord_value = shift_reg ? point[k] ^ shift_words[k] : point[k];
         r.status = 1'b0;
         r.last_of_point = (k == n - 1);
         coord_queue.push_back(r);
      end
   endfunction

   // Advance the generator by one accepted request word and queue what it emits.
   function automatic void predict_word(cmd_type c, logic [3:0] d, logic [4:0] k,
                                        logic [31:0] w);
      logic [31:0] gray;
      int col;
      int dd;
      int cc;
      case (c)
         CMD_LOAD_DIR: begin
            if (int'(d) < MAX_DIMS && int'(k) < NUM_COLS) dir_words[d][k] = w;
         end
         CMD_LOAD_SHIFT: begin
            if (int'(d) < MAX_DIMS) shift_words[d] = w;
         end
         CMD_RESTART: begin
            // build the point from scratch out of the Gray code of the start index
            gray = start_reg ^ (start_reg >> 1);
            seq_index = start_reg;
            for (dd = 0; dd < MAX_DIMS; dd++) point[dd] = '0;
            if (64'(start_reg) > LAST_INDEX) begin
               coord_queue.push_back(EXHAUSTED_WORD);
            end else begin
               for (dd = 0; dd < MAX_DIMS; dd++)
                  for (cc = 0; cc < NUM_COLS; cc++)
                     if (gray[cc]) point[dd] ^= dir_words[dd][cc];
               queue_point();
            end
         end
         CMD_NEXT: begin
            // a failed next leaves index and point alone
            if (64'(seq_index) >= LAST_INDEX) begin
               coord_queue.push_back(EXHAUSTED_WORD);
            end else begin
               col = 0;
               while (col < NUM_COLS - 1 && seq_index[col]) col++;
               // every dimension advances, not only the ones emitted
               for (dd = 0; dd < MAX_DIMS; dd++) point[dd] ^= dir_words[dd][col];
               seq_index = seq_index + 32'd1;
               queue_point();
            end
         end
         default: ;
      endcase
   endfunction

   function automatic plan_row_type item_row(cmd_type c, logic [3:0] d, logic [4:0] k,
                                             logic [31:0] w);
      plan_row_type r;
      r.is_csr = 1'b0;
      r.reg_sel = CSR_DIMS_IN_USE;
      r.reg_value = '0;
      r.cmd = c;
      r.dim = d;
      r.col = k;
      r.word = w;
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic plan_row_type csr_row(csr_index_type sel, logic [31:0] v);
      plan_row_type r;
      r = item_row(CMD_NEXT, '0, '0, '0);
      r.is_csr = 1'b1;
      r.reg_sel = sel;
      r.reg_value = v;
      return r;
   endfunction

   // A next word whose single result is known without the predictor.
   function automatic plan_row_type known_next_row(result_type want);
      plan_row_type r;
      r = item_row(CMD_NEXT, '0, '0, '0);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   // Offer one request word, with random idle cycles ahead of it, until it is taken.
   // Call and return at a falling edge.
   task automatic send_word(cmd_type c, logic [3:0] d, logic [4:0] k, logic [31:0] w);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_cmd <= c;
      req_dim_index <= d;
      req_column_index <= k;
      req_load_word <= w;
      // full is sampled before the edge updates it
      @(posedge clock);
      while (full) @(posedge clock);
      predict_word(c, d, k, w);
      words_sent++;
      @(negedge clock);
   endtask

   // Hold the request side and let every expected word come back, plus trailing loads.
   task automatic drain();
      push <= 1'b0;
      while (coord_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write a register, read it back, and update the predictor's copy.
   task automatic write_csr(csr_index_type sel, logic [31:0] value);
      logic [31:0] mask;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      // turn the access straight into the setup of a read
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (sel)
         CSR_DIMS_IN_USE: begin
            mask = 32'h0000_001F;
            dims_reg = value[4:0];
         end
         CSR_SHIFT_ENABLE: begin
            mask = 32'h0000_0001;
            shift_reg = value[0];
         end
         default: begin
            mask = 32'hFFFF_FFFF;
            start_reg = value;
         end
      endcase
      if (prdata !== (value & mask)) begin
         $error("%s readback: expected %h, actual %h", sel.name(), value & mask, prdata);
         failures++;
      end
      csr_writes++;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Stall the result side at random, except during the steady stretch.
   always @(negedge clock) pop <= !reset && (steady || $urandom_range(99) >= IDLE_PERCENT);

   // Check each popped word against the oldest expectation; track bus activity.
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if ((push && !full) || (pop && !empty) || (psel && penable && pready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (pop && !empty) begin
            if (coord_queue.size() == 0) begin
               $error("unexpected coordinate word: dim %0d value %h status %b last %b",
                      rsp_coord_dim, rsp_coord_value, rsp_status, rsp_last_of_point);
               failures++;
            end else begin
               want = coord_queue.pop_front();
               coords_checked++;
               if (want.status) exhausted_seen++;
               if (rsp_coord_dim !== want.coord_dim) begin
                  $error("coord_dim: expected %0d, actual %0d", want.coord_dim, rsp_coord_dim);
                  failures++;
               end
               if (rsp_coord_value !== want.coord_value) begin
                  $error("coord_value: expected %h, actual %h",
                         want.coord_value, rsp_coord_value);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %b, actual %b", want.status, rsp_status);
                  failures++;
               end
               if (rsp_last_of_point !== want.last_of_point) begin
                  $error("last_of_point: expected %b, actual %b",
                         want.last_of_point, rsp_last_of_point);
                  failures++;
               end
            end
         end
      end
   end

   // Watchdog: end the run once nothing has moved for too long.
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Timeout: %0d cycles without a word moving", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      plan_row_type plan [$];
      plan_row_type row;
      cmd_type pick_cmd;
      logic [31:0] start_pick;
      int pick;
      int ph;
      int i;
      int dd;
      int cc;

      // predictor reset state; the tables stay unknown until the fill below
      seq_index = '0;
      for (dd = 0; dd < MAX_DIMS; dd++) point[dd] = '0;
      dims_reg = 5'd1;
      shift_reg = 1'b0;
      start_reg = '0;

      // Directed plan. Dimension 0 holds the van der Corput columns, so its
      // first point after reset is one half.
      plan.push_back(known_next_row({4'd0, 32'h8000_0000, 1'b0, 1'b1}));
      plan.push_back(item_row(CMD_NEXT, 4'd0, 5'd0, 32'h0));
      plan.push_back(item_row(CMD_NEXT, 4'd15, 5'd31, 32'hFFFF_FFFF));
      // field extremes on loads
      plan.push_back(item_row(CMD_LOAD_DIR, 4'd15, 5'd31, 32'hFFFF_FFFF));
      plan.push_back(item_row(CMD_LOAD_DIR, 4'd7, 5'd5, 32'h0000_0000));
      plan.push_back(item_row(CMD_LOAD_SHIFT, 4'd15, 5'd0, 32'hFFFF_FFFF));
      plan.push_back(item_row(CMD_LOAD_SHIFT, 4'd0, 5'd31, 32'h0000_0000));
      // full width with the shift applied; restart from zero gives the shift words
      plan.push_back(csr_row(CSR_DIMS_IN_USE, 32'd16));
      plan.push_back(csr_row(CSR_SHIFT_ENABLE, 32'd1));
      plan.push_back(item_row(CMD_RESTART, 4'd3, 5'd9, 32'hDEAD_BEEF));
      plan.push_back(item_row(CMD_NEXT, 4'd0, 5'd0, 32'h0));
      plan.push_back(item_row(CMD_NEXT, 4'd0, 5'd0, 32'h0));
      // a zero count behaves as one
      plan.push_back(csr_row(CSR_DIMS_IN_USE, 32'd0));
      plan.push_back(item_row(CMD_NEXT, 4'd0, 5'd0, 32'h0));
      // oversized count saturates; run to the top of the index and past it
      plan.push_back(csr_row(CSR_DIMS_IN_USE, 32'd31));
      plan.push_back(csr_row(CSR_SHIFT_ENABLE, 32'd0));
      plan.push_back(csr_row(CSR_START_INDEX, 32'hFFFF_FFFE));
      plan.push_back(item_row(CMD_RESTART, 4'd0, 5'd0, 32'h0));
      plan.push_back(item_row(CMD_NEXT, 4'd0, 5'd0, 32'h0));
      plan.push_back(known_next_row(EXHAUSTED_WORD));
      plan.push_back(known_next_row(EXHAUSTED_WORD));
      // carry through every low bit: the next step uses the top column
      plan.push_back(csr_row(CSR_START_INDEX, 32'h7FFF_FFFF));
      plan.push_back(csr_row(CSR_DIMS_IN_USE, 32'd5));
      plan.push_back(item_row(CMD_RESTART, 4'd0, 5'd0, 32'h0));
      plan.push_back(item_row(CMD_NEXT, 4'd0, 5'd0, 32'h0));
      // table and shift updates between points
      plan.push_back(csr_row(CSR_DIMS_IN_USE, 32'd3));
      plan.push_back(csr_row(CSR_SHIFT_ENABLE, 32'd1));
      plan.push_back(csr_row(CSR_START_INDEX, 32'd5));
      plan.push_back(item_row(CMD_LOAD_SHIFT, 4'd1, 5'd0, 32'hA5A5_5A5A));
      plan.push_back(item_row(CMD_RESTART, 4'd0, 5'd0, 32'h0));
      plan.push_back(item_row(CMD_NEXT, 4'd0, 5'd0, 32'h0));
      plan.push_back(item_row(CMD_LOAD_DIR, 4'd0, 5'd3, 32'h1234_5678));
      plan.push_back(item_row(CMD_NEXT, 4'd0, 5'd0, 32'h0));

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill every direction and shift word so that no read ever hits an unwritten entry.
      for (dd = 0; dd < MAX_DIMS; dd++)
         for (cc = 0; cc < NUM_COLS; cc++)
            send_word(CMD_LOAD_DIR, 4'(dd), 5'(cc),
                      (dd == 0) ? (32'h8000_0000 >> cc) : $urandom());
      for (dd = 0; dd < MAX_DIMS; dd++)
         send_word(CMD_LOAD_SHIFT, 4'(dd), 5'($urandom_range(31)), $urandom());

      // Walk the directed plan; register writes wait for the block to go idle.
      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_csr) begin
            drain();
            write_csr(row.reg_sel, row.reg_value);
         end else begin
            send_word(row.cmd, row.dim, row.col, row.word);
            if (row.typed) begin
               // swap in the hand-written answer; its word cannot have been popped yet
               void'(coord_queue.pop_back());
               coord_queue.push_back(row.want);
            end
         end
      end

      // Random phases: new settings, mostly a restart followed by runs of next words,
      // with restarts and table loads mixed in. Phases 2 and 3 run without idling.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         steady = (ph == 2 || ph == 3);
         write_csr(CSR_DIMS_IN_USE, (ph == 0) ? 32'd16 : (ph == 1) ? 32'd1
                                                  : 32'($urandom_range(31)));
         write_csr(CSR_SHIFT_ENABLE, 32'($urandom_range(1)));
         case ($urandom_range(4))
            0: start_pick = 32'($urandom_range(15));
            1: start_pick = 32'($urandom_range(4095));
            2: start_pick = $urandom();
            3: start_pick = 32'hFFFF_FFFF - 32'($urandom_range(20));
            default: start_pick = 32'h7FFF_FFFF - 32'($urandom_range(20));
         endcase
         write_csr(CSR_START_INDEX, start_pick);
         if ($urandom_range(9) != 0)
            send_word(CMD_RESTART, 4'($urandom_range(15)), 5'($urandom_range(31)), $urandom());
         for (i = 0; i < WORDS_PER_PHASE; i++) begin
            pick = $urandom_range(99);
            if (pick < 60) pick_cmd = CMD_NEXT;
            else if (pick < 72) pick_cmd = CMD_RESTART;
            else if (pick < 88) pick_cmd = CMD_LOAD_DIR;
            else pick_cmd = CMD_LOAD_SHIFT;
            send_word(pick_cmd, 4'($urandom_range(15)), 5'($urandom_range(31)), $urandom());
         end
      end
      steady = 1'b0;
      push <= 1'b0;

      // Wait out every expected word, then linger for anything extra.
      while (coord_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request words over %0d register writes and %0d random phases;",
               words_sent, csr_writes, RANDOM_PHASES);
      $display("checked %0d coordinate words, %0d of them exhausted-index reports.",
               coords_checked, exhausted_seen);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sobol_point_generator_core.f
rtl/core/spg_pkg.sv
rtl/core/spg_ram.sv
rtl/core/spg_fifo.sv
rtl/core/spg_front.sv
rtl/core/spg_back.sv
rtl/core/sobol_point_generator_core.sv
rtl/core/spg_checker.sv
bench/sobol_point_generator_core_tb.sv
